// ----- rtl/isru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_pkg
// Shared widths, constants and item structs for the ISRU value/slope pipeline.
// ----------------------------------------------------------------------------
package isru_pkg;

	localparam int X_W    = 16;            // Q4.12 sample / alpha
	localparam int D_W    = 46;            // D = 2^36 + alpha*x^2, when positive
	localparam int S_W    = 31;            // floor(sqrt(D * 2^16))
	localparam int N_W    = 42;            // |x|*2^26 + S/2
	localparam int P_W    = 77;            // D * S
	localparam int VQ_W   = 16;            // value quotient bits
	localparam int SL_W   = 32;            // slope quotient bits
	localparam int SQ_RW  = S_W + 3;       // sqrt remainder width
	localparam int PPH_W  = D_W - 32 + S_W;
	localparam int PPL_W  = 32 + S_W;

	localparam logic signed [X_W-1:0] ALPHA_RESET = 16'sd4096;
	localparam logic signed [47:0]    D_ONE       = 48'sh10_0000_0000;
	localparam logic [P_W-1:0]        P_SAT       = P_W'(1) << 46;
	localparam logic [P_W:0]          SL_REM_INIT = (P_W+1)'(1) << 46;
	localparam logic signed [X_W-1:0] V_MAX       = 16'sh7FFF;
	localparam logic signed [X_W-1:0] V_MIN       = 16'sh8000;
	localparam logic [SL_W-1:0]       SL_MAX      = '1;

	typedef struct packed {
		logic           inv;
		logic           neg;
		logic [X_W-1:0] mag;
		logic [D_W-1:0] d;
	} side_a_t;

	typedef struct packed {
		logic           inv;
		logic           neg;
		logic           vovf;
		logic           psat;
		logic [15:0]    nlo;
		logic [P_W-1:0] p;
	} side_b_t;

	typedef struct packed {
		logic                  inv;
		logic                  psat;
		logic signed [X_W-1:0] value;
	} side_c_t;

endpackage

// ----- rtl/isru_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_sample_if
// Input channel: one Q4.12 sample per item.
// ----------------------------------------------------------------------------
interface isru_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [isru_pkg::X_W-1:0]      sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- rtl/isru_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_result_if
// Output channel: value, slope and invalid flag per item.
// ----------------------------------------------------------------------------
interface isru_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [isru_pkg::X_W-1:0]      value;
	logic [isru_pkg::SL_W-1:0]            slope;
	logic                                 invalid;

	modport source (output valid, output value, output slope, output invalid, input ready);
	modport sink (input valid, input value, input slope, input invalid, output ready);
endinterface

// ----- rtl/isru_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_cfg_if
// Configuration write channel for the alpha register.
// ----------------------------------------------------------------------------
interface isru_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [isru_pkg::X_W-1:0]      alpha;

	modport source (output valid, output alpha, input ready);
	modport sink (input valid, input alpha, output ready);
endinterface

// ----- rtl/isru_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_sqrt_cell
// One restoring square-root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module isru_sqrt_cell #(
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [1:0]    in_pair,
	input  logic [QW+2:0] in_rem,
	input  logic [QW-1:0] in_root,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW+2:0] out_rem,
	output logic [QW-1:0] out_root,
	output logic [SW-1:0] out_side
);

	localparam int RW = QW + 3;

	logic [RW-1:0] t_rem;
	logic [RW-1:0] trial;
	logic          ge;

	always_comb begin
		t_rem = {in_rem[RW-3:0], in_pair};
		trial = RW'({in_root, 2'b01});
		ge    = t_rem >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= ge ? t_rem - trial : t_rem;
			out_root <= {in_root[QW-2:0], ge};
			out_side <= in_side;
		end
	end

endmodule

// ----- rtl/isru_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_div_cell
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module isru_div_cell #(
	parameter int DW = 31,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic          in_bit,
	input  logic [DW:0]   in_rem,
	input  logic [DW-1:0] in_dvs,
	input  logic [QW-1:0] in_quo,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [DW:0]   out_rem,
	output logic [DW-1:0] out_dvs,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);

	logic [DW:0] t_rem;
	logic [DW:0] dvs_x;
	logic        ge;

	always_comb begin
		t_rem = {in_rem[DW-1:0], in_bit};
		dvs_x = {1'b0, in_dvs};
		ge    = t_rem >= dvs_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem  <= ge ? t_rem - dvs_x : t_rem;
			out_dvs  <= in_dvs;
			out_quo  <= {in_quo[QW-2:0], ge};
			out_side <= in_side;
		end
	end

endmodule

// ----- rtl/isru_value_and_slope.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_value_and_slope
// ISRU value x/sqrt(1+alpha*x^2) and slope (1+alpha*x^2)^(-3/2) in fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per cycle while the output is not held
// (square registers s1 and s2, 31 square-root cells, 1 multiply stage,
// 16 value-division cells, 32 slope-division cells, 1 output register).
// The whole pipeline holds while a result waits at the output and the sink
// is not ready; din.ready follows that hold. alpha is written over cfg
// (always ready) and must only change while no item is in flight.
module isru_value_and_slope (
	input  logic          clk,
	input  logic          arst_n,
	isru_sample_if.sink   din,
	isru_result_if.source dout,
	isru_cfg_if.sink      cfg
);

	localparam int SQ_N = isru_pkg::S_W;
	localparam int VQ_N = isru_pkg::VQ_W;
	localparam int SL_N = isru_pkg::SL_W;

	logic en;
	logic signed [isru_pkg::X_W-1:0] alpha_q;

	assign en        = !dout.valid || dout.ready;
	assign din.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= isru_pkg::ALPHA_RESET;
		end else if (cfg.valid) begin
			alpha_q <= cfg.alpha;
		end
	end

	// squares
	logic                        vld_s1, vld_s2;
	logic [30:0]                 x2_s1;
	logic                        neg_s1;
	logic [isru_pkg::X_W-1:0]    mag_s1;
	logic signed [31:0]          xsq;
	logic signed [47:0]          ax;
	logic signed [47:0]          dsum;
	isru_pkg::side_a_t           side_s2;

	always_comb begin
		xsq  = din.sample * din.sample;
		ax   = alpha_q * $signed({1'b0, x2_s1});
		dsum = ax + isru_pkg::D_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1        <= xsq[30:0];
			neg_s1       <= din.sample[isru_pkg::X_W-1];
			mag_s1       <= din.sample[isru_pkg::X_W-1] ? 16'(-din.sample) : din.sample;
			side_s2.inv  <= dsum[47] || (dsum == '0);
			side_s2.neg  <= neg_s1;
			side_s2.mag  <= mag_s1;
			side_s2.d    <= dsum[isru_pkg::D_W-1:0];
		end
	end

	// square root chain
	logic                        sq_vld  [SQ_N+1];
	logic [isru_pkg::SQ_RW-1:0]  sq_rem  [SQ_N+1];
	logic [isru_pkg::S_W-1:0]    sq_root [SQ_N+1];
	isru_pkg::side_a_t           sq_side [SQ_N+1];
	logic [2*SQ_N-1:0]           sq_rad  [SQ_N];

	assign sq_vld[0]  = vld_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s2;

	for (genvar i = 0; i < SQ_N; i++) begin : g_sq
		localparam int K = SQ_N - 1 - i;
		assign sq_rad[i] = {sq_side[i].d, 16'b0};
		isru_sqrt_cell #(
			.QW(isru_pkg::S_W),
			.SW($bits(isru_pkg::side_a_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (sq_vld[i]),
			.in_pair  (sq_rad[i][2*K+1 -: 2]),
			.in_rem   (sq_rem[i]),
			.in_root  (sq_root[i]),
			.in_side  (sq_side[i]),
			.out_vld  (sq_vld[i+1]),
			.out_rem  (sq_rem[i+1]),
			.out_root (sq_root[i+1]),
			.out_side (sq_side[i+1])
		);
	end

	// rounding numerator, overflow check, D*S partial products
	logic                         vld_m1;
	logic                         inv_m1, neg_m1, vovf_m1;
	logic [isru_pkg::N_W-1:0]     nv_m1;
	logic [isru_pkg::S_W-1:0]     s_m1;
	logic [isru_pkg::PPH_W-1:0]   pph_m1;
	logic [isru_pkg::PPL_W-1:0]   ppl_m1;
	logic [isru_pkg::N_W-1:0]     nv;
	logic [isru_pkg::P_W-1:0]     prod;
	isru_pkg::side_a_t            sa_f;
	isru_pkg::side_b_t            side_b0;

	always_comb begin
		sa_f = sq_side[SQ_N];
		nv   = {sa_f.mag, 26'b0} + isru_pkg::N_W'(sq_root[SQ_N] >> 1);
		prod = {pph_m1, 32'b0} + isru_pkg::P_W'(ppl_m1);
		side_b0.inv  = inv_m1;
		side_b0.neg  = neg_m1;
		side_b0.vovf = vovf_m1;
		side_b0.psat = prod <= isru_pkg::P_SAT;
		side_b0.nlo  = nv_m1[15:0];
		side_b0.p    = prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
		end else if (en) begin
			vld_m1 <= sq_vld[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_m1  <= sa_f.inv;
			neg_m1  <= sa_f.neg;
			vovf_m1 <= 47'(nv) >= {sq_root[SQ_N], 16'b0};
			nv_m1   <= nv;
			s_m1    <= sq_root[SQ_N];
			pph_m1  <= sa_f.d[isru_pkg::D_W-1:32] * sq_root[SQ_N];
			ppl_m1  <= sa_f.d[31:0] * sq_root[SQ_N];
		end
	end

	// value division chain
	logic                       vd_vld  [VQ_N+1];
	logic [isru_pkg::S_W:0]     vd_rem  [VQ_N+1];
	logic [isru_pkg::S_W-1:0]   vd_dvs  [VQ_N+1];
	logic [VQ_N-1:0]            vd_quo  [VQ_N+1];
	isru_pkg::side_b_t          vd_side [VQ_N+1];

	assign vd_vld[0]  = vld_m1;
	assign vd_rem[0]  = (isru_pkg::S_W+1)'(nv_m1[isru_pkg::N_W-1:16]);
	assign vd_dvs[0]  = s_m1;
	assign vd_quo[0]  = '0;
	assign vd_side[0] = side_b0;

	for (genvar j = 0; j < VQ_N; j++) begin : g_vd
		isru_div_cell #(
			.DW(isru_pkg::S_W),
			.QW(VQ_N),
			.SW($bits(isru_pkg::side_b_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vd_vld[j]),
			.in_bit   (vd_side[j].nlo[VQ_N-1-j]),
			.in_rem   (vd_rem[j]),
			.in_dvs   (vd_dvs[j]),
			.in_quo   (vd_quo[j]),
			.in_side  (vd_side[j]),
			.out_vld  (vd_vld[j+1]),
			.out_rem  (vd_rem[j+1]),
			.out_dvs  (vd_dvs[j+1]),
			.out_quo  (vd_quo[j+1]),
			.out_side (vd_side[j+1])
		);
	end

	// value saturation
	isru_pkg::side_b_t vb_f;
	isru_pkg::side_c_t side_c0;
	logic [VQ_N-1:0]   q;

	always_comb begin
		vb_f = vd_side[VQ_N];
		q    = vd_quo[VQ_N];
		side_c0.inv  = vb_f.inv;
		side_c0.psat = vb_f.psat;
		if (vb_f.neg) begin
			side_c0.value = (vb_f.vovf || q > 16'd32768) ? isru_pkg::V_MIN : 16'(-q);
		end else begin
			side_c0.value = (vb_f.vovf || q > 16'd32767) ? isru_pkg::V_MAX : q;
		end
	end

	// slope division chain
	logic                       sd_vld  [SL_N+1];
	logic [isru_pkg::P_W:0]     sd_rem  [SL_N+1];
	logic [isru_pkg::P_W-1:0]   sd_dvs  [SL_N+1];
	logic [SL_N-1:0]            sd_quo  [SL_N+1];
	isru_pkg::side_c_t          sd_side [SL_N+1];

	assign sd_vld[0]  = vd_vld[VQ_N];
	assign sd_rem[0]  = isru_pkg::SL_REM_INIT;
	assign sd_dvs[0]  = vb_f.p;
	assign sd_quo[0]  = '0;
	assign sd_side[0] = side_c0;

	for (genvar k = 0; k < SL_N; k++) begin : g_sd
		isru_div_cell #(
			.DW(isru_pkg::P_W),
			.QW(SL_N),
			.SW($bits(isru_pkg::side_c_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (sd_vld[k]),
			.in_bit   (1'b0),
			.in_rem   (sd_rem[k]),
			.in_dvs   (sd_dvs[k]),
			.in_quo   (sd_quo[k]),
			.in_side  (sd_side[k]),
			.out_vld  (sd_vld[k+1]),
			.out_rem  (sd_rem[k+1]),
			.out_dvs  (sd_dvs[k+1]),
			.out_quo  (sd_quo[k+1]),
			.out_side (sd_side[k+1])
		);
	end

	// output register
	logic                            out_vld_q;
	logic signed [isru_pkg::X_W-1:0] value_q;
	logic [SL_N-1:0]                 slope_q;
	logic                            inv_q;
	isru_pkg::side_c_t               sc_f;

	assign sc_f = sd_side[SL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sd_vld[SL_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q   <= sc_f.inv;
			value_q <= sc_f.inv ? '0 : sc_f.value;
			slope_q <= sc_f.inv ? '0 : (sc_f.psat ? isru_pkg::SL_MAX : sd_quo[SL_N]);
		end
	end

	assign dout.valid   = out_vld_q;
	assign dout.value   = value_q;
	assign dout.slope   = slope_q;
	assign dout.invalid = inv_q;

`ifndef SYNTH
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.invalid |-> dout.value == '0 && dout.slope == '0)
		else $error("invalid item with nonzero result");

	a_slope_nz: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.invalid |-> dout.slope != '0)
		else $error("valid item with zero slope");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sd_vld[SL_N]) && $stable(vld_m1))
		else $error("pipeline moved while held");
`endif

endmodule

// ----- dv/isru_value_and_slope_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_value_and_slope_test
// Self-checking bench for the ISRU value/slope pipeline. Samples are streamed
// under several alpha settings, including the extremes. Each accepted result
// is compared field by field against an in-bench fixed-point calculation.
// Both channels idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module isru_value_and_slope_test;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic signed [15:0] value;
		logic [31:0]        slope;
		logic               invalid;
	} isru_out_t;

	class isru_ledger;
		logic signed [15:0] alpha;
		isru_out_t          pending_results[$];
		int                 errors;
		int                 n_checked;
		int                 n_invalid;
		int                 n_vsat;
		int                 n_ssat;

		function new();
			alpha = isru_pkg::ALPHA_RESET;
		endfunction

		function automatic logic [63:0] root64(logic [63:0] n);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function automatic isru_out_t isru_eval(logic signed [15:0] x);
			isru_out_t r;
			longint signed d;
			logic [63:0] dd;
			logic [63:0] s;
			logic [63:0] mag;
			logic [63:0] q;
			logic [79:0] p;
			d = (64'sd1 <<< 36) + longint'(alpha) * longint'(x) * longint'(x);
			if (d <= 0) begin
				r.value = 0;
				r.slope = 0;
				r.invalid = 1;
				return r;
			end
			dd = d;
			s = root64(dd << 16);
			mag = (x < 0) ? 64'(-longint'(x)) : 64'(x);
			mag <<= 26;
			q = (mag + (s >> 1)) / s;
			if (x < 0)
				r.value = (q > 32768) ? isru_pkg::V_MIN : -16'(q);
			else
				r.value = (q > 32767) ? isru_pkg::V_MAX : 16'(q);
			p = 80'(dd) * 80'(s);
			if (p <= (80'd1 << 46))
				r.slope = isru_pkg::SL_MAX;
			else
				r.slope = 32'((80'd1 << 78) / p);
			r.invalid = 0;
			return r;
		endfunction

		function void note_sample(logic signed [15:0] x);
			pending_results.push_back(isru_eval(x));
		endfunction

		function void check_result(logic signed [15:0] v, logic [31:0] sl, logic inv);
			isru_out_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%0d slope=%h invalid=%b",
					$time, v, sl, inv);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			n_checked++;
			if (e.invalid) n_invalid++;
			if (!e.invalid && (e.value == isru_pkg::V_MAX || e.value == isru_pkg::V_MIN))
				n_vsat++;
			if (!e.invalid && e.slope == isru_pkg::SL_MAX) n_ssat++;
			if (v !== e.value) begin
				$display("%0t: value expected %0d actual %0d", $time, e.value, v);
				errors++;
			end
			if (sl !== e.slope) begin
				$display("%0t: slope expected %h actual %h", $time, e.slope, sl);
				errors++;
			end
			if (inv !== e.invalid) begin
				$display("%0t: invalid expected %b actual %b", $time, e.invalid, inv);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	isru_sample_if din_ch();
	isru_result_if res_ch();
	isru_cfg_if    cfg_ch();
	isru_ledger    book;
	bit            hold_req;
	bit            eager;
	int            stall_cycles;

	isru_value_and_slope dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (res_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		book = new();
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (din_ch.valid && din_ch.ready)
				book.note_sample(din_ch.sample);
			if (res_ch.valid && res_ch.ready)
				book.check_result(res_ch.value, res_ch.slope, res_ch.invalid);
			if (cfg_ch.valid && cfg_ch.ready)
				book.alpha = cfg_ch.alpha;
			if ((din_ch.valid && din_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver
	initial begin
		int n;
		res_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				n = eager ? 0 : $urandom_range(0, 4);
				if (n > 0) begin
					res_ch.ready <= 0;
					repeat (n) @(posedge clk);
				end
			end
			res_ch.ready <= 1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	task automatic send_sample(logic signed [15:0] x);
		int n;
		n = eager ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			din_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		din_ch.valid <= 1;
		din_ch.sample <= x;
		do @(posedge clk); while (!din_ch.ready);
	endtask

	task automatic settle();
		din_ch.valid <= 0;
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_alpha(logic signed [15:0] a);
		settle();
		cfg_ch.valid <= 1;
		cfg_ch.alpha <= a;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 2))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 8192)) - 16'sd4096;
			default: return 16'($urandom_range(0, 512)) + 16'sd1200;
		endcase
	endfunction

	task automatic run_directed();
		logic signed [15:0] pts[] = '{16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096,
			16'sh7FFF, 16'sh8000, 16'sd1448, -16'sd1448, 16'sd1449, -16'sd1449,
			16'sd2048, 16'sh5555, 16'shAAAA};
		foreach (pts[i])
			send_sample(pts[i]);
	endtask

	initial begin
		logic signed [15:0] alphas[] = '{isru_pkg::ALPHA_RESET, 16'sh8000, 16'sh7FFF,
			16'sd0, -16'sd1, 16'sd1, 16'($urandom), 16'($urandom), -16'sd4096};
		din_ch.valid = 0;
		din_ch.sample = 0;
		cfg_ch.valid = 0;
		cfg_ch.alpha = 0;
		@(posedge arst_n);
		@(posedge clk);
		foreach (alphas[p]) begin
			if (p > 0)
				write_alpha(alphas[p]);
			eager = (p % 3 == 2);
			if (p == 2)
				hold_req = 1;
			if (p < 6)
				run_directed();
			repeat (90)
				send_sample(rand_sample());
		end
		settle();
		book.errors += book.pending_results.size();
		$display("checked %0d results over %0d alpha settings", book.n_checked,
			alphas.size());
		$display("invalid %0d, value clamped %0d, slope clamped %0d",
			book.n_invalid, book.n_vsat, book.n_ssat);
		if (book.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/isru_pkg.sv
rtl/isru_sample_if.sv
rtl/isru_result_if.sv
rtl/isru_cfg_if.sv
rtl/isru_sqrt_cell.sv
rtl/isru_div_cell.sv
rtl/isru_value_and_slope.sv
dv/isru_value_and_slope_test.sv
